### design/hrpi_pkg.sv
// Shared types and constants for the heart rate from peak interval block.
package hrpi_pkg;

    localparam int RATE_W      = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_RATE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEFAULT_RATE  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SMOOTH_ENABLE = 2'd2;

    localparam logic [15:0]       SAMPLE_RATE_RST  = 16'd250;
    localparam logic [RATE_W-1:0] DEFAULT_RATE_RST = '0;
    localparam logic [RATE_W-1:0] RATE_MAX         = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

### design/heart_rate_from_peak_interval.sv
// Top level: heart rate in beats per minute from the spacing of R peaks.
//
// Input channel (i_valid / o_ready) carries one detector sample per request:
// i_peak marks an R peak, i_frame_end marks the last sample of a frame.
// Output channel (o_valid / i_ready) carries one o_heart_rate request for each
// sample with i_frame_end set; the rate includes that sample's own peak.
// Rate is unsigned fixed point with RATE_FRAC_BITS fractional bits, saturated.
// Flow: a sample without a peak interval is taken in ST_IDLE. A peak after the
// first starts a bit-serial divide, one quotient bit per cycle over 17 bits,
// and no further sample is taken until the divide is done. A frame end then
// passes through ST_EMIT to hand the rate to the output register.
// Path to o_valid: ST_IDLE, ST_DIV when dividing, ST_EMIT, output register.
// The output register parts the channels: new samples are taken while a rate
// waits; only a further frame end waits for i_ready.
// Configuration writes (i_cfg_we) are registered; writing default_rate
// also reloads the current rate. Reset (synchronous, active low) restores
// sample_rate 250, default_rate 0, smoothing off, and clears index state.
module heart_rate_from_peak_interval #(
    parameter int INDEX_WIDTH    = 32,
    parameter int RATE_FRAC_BITS = 7
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [hrpi_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [hrpi_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // sample input
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_peak,
    input  logic                              i_frame_end,
    // rate output
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [hrpi_pkg::RATE_W-1:0]       o_heart_rate
);

    localparam int RW = hrpi_pkg::RATE_W;

    hrpi_pkg::t_state r_state, n_state;

    logic [15:0]            r_sample_rate;
    logic                   r_smooth;
    logic [INDEX_WIDTH-1:0] r_index, n_index;
    logic [INDEX_WIDTH-1:0] r_last_peak, n_last_peak;
    logic                   r_have_peak, n_have_peak;
    logic [RW-1:0]          r_rate, n_rate;
    logic                   r_fe, n_fe;
    logic                   r_out_valid, n_out_valid;
    logic [RW-1:0]          r_out_data, n_out_data;

    logic                   accept;
    logic                   div_start;
    logic [INDEX_WIDTH-1:0] interval;
    logic [RW:0]            smooth_sum;
    hrpi_pkg::t_div_status  div_status;
    logic [RW-1:0]          div_quot;

    assign interval = r_index - r_last_peak;

    hrpi_div #(
        .INDEX_WIDTH    (INDEX_WIDTH),
        .RATE_FRAC_BITS (RATE_FRAC_BITS)
    ) u_div (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (div_start),
        .i_sample_rate (r_sample_rate),
        .i_interval    (interval),
        .o_status      (div_status),
        .o_quot        (div_quot)
    );

    // Next state and datapath control
    always_comb begin
        n_state     = r_state;
        n_index     = r_index;
        n_last_peak = r_last_peak;
        n_have_peak = r_have_peak;
        n_rate      = r_rate;
        n_fe        = r_fe;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        o_ready     = 1'b0;
        accept      = 1'b0;
        div_start   = 1'b0;
        smooth_sum  = {1'b0, div_quot} + {1'b0, r_rate};

        // output register drains independently
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            hrpi_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                accept  = i_valid;
                if (accept) begin
                    n_index = r_index + 1'b1;
                    n_fe    = i_frame_end;
                    if (i_peak) begin
                        n_last_peak = r_index;
                        n_have_peak = 1'b1;
                    end
                    if (i_peak && r_have_peak) begin
                        div_start = 1'b1;
                        n_state   = hrpi_pkg::ST_DIV;
                    end else if (i_frame_end) begin
                        n_state = hrpi_pkg::ST_EMIT;
                    end
                end
            end
            hrpi_pkg::ST_DIV: begin
                if (div_status.done) begin
                    // average is never above the larger operand, no clamp needed
                    n_rate  = r_smooth ? smooth_sum[RW:1] : div_quot;
                    n_state = r_fe ? hrpi_pkg::ST_EMIT : hrpi_pkg::ST_IDLE;
                end
            end
            hrpi_pkg::ST_EMIT: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_rate;
                    n_state     = hrpi_pkg::ST_IDLE;
                end
            end
            default: n_state = hrpi_pkg::ST_IDLE;
        endcase

        // default_rate write restarts the rate
        if (i_cfg_we && i_cfg_index == hrpi_pkg::CFG_DEFAULT_RATE) begin
            n_rate = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hrpi_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_rate  <= hrpi_pkg::SAMPLE_RATE_RST;
            r_smooth       <= 1'b0;
            r_index        <= '0;
            r_last_peak    <= '0;
            r_have_peak    <= 1'b0;
            r_rate         <= hrpi_pkg::DEFAULT_RATE_RST;
            r_fe           <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_index     <= n_index;
            r_last_peak <= n_last_peak;
            r_have_peak <= n_have_peak;
            r_rate      <= n_rate;
            r_fe        <= n_fe;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    hrpi_pkg::CFG_SAMPLE_RATE:   r_sample_rate  <= i_cfg_data;
                    // only reloads the live rate, see n_rate
                    hrpi_pkg::CFG_DEFAULT_RATE:  ;
                    hrpi_pkg::CFG_SMOOTH_ENABLE: r_smooth       <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_valid      = r_out_valid;
    assign o_heart_rate = r_out_data;

endmodule

### design/hrpi_div.sv
// Bit-serial restoring divider: rate = round(60 * fs * 2^frac / interval), saturated.
module hrpi_div #(
    parameter int INDEX_WIDTH    = 32,
    parameter int RATE_FRAC_BITS = 7
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [15:0]                i_sample_rate,
    input  logic [INDEX_WIDTH-1:0]     i_interval,
    output hrpi_pkg::t_div_status      o_status,
    output logic [hrpi_pkg::RATE_W-1:0] o_quot
);

    localparam int QB    = hrpi_pkg::RATE_W + 1;
    localparam int NUM_W = 22 + RATE_FRAC_BITS;
    localparam int DW    = ((NUM_W > INDEX_WIDTH - 1) ? NUM_W : INDEX_WIDTH - 1) + 1;
    localparam int CW    = (DW > INDEX_WIDTH + QB) ? DW : INDEX_WIDTH + QB;
    localparam int CNT_W = $clog2(QB + 1);

    logic [CW-1:0]    r_rem, r_dvs;
    logic [QB-1:0]    r_q;
    logic             r_sat, r_busy, r_done;
    logic [CNT_W-1:0] r_cnt;

    logic [CW-1:0] sr_ext, num, dividend, dvs_top;
    logic [CW-1:0] diff;
    logic          ge;

    always_comb begin
        sr_ext   = CW'(i_sample_rate);
        // 60 * fs as 64 fs - 4 fs
        num      = ((sr_ext << 6) - (sr_ext << 2)) << RATE_FRAC_BITS;
        dividend = num + CW'(i_interval >> 1);
        dvs_top  = CW'(i_interval) << QB;
        diff     = r_rem - r_dvs;
        ge       = (r_rem >= r_dvs);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(QB);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= dividend;
            r_dvs <= dvs_top >> 1;
            r_q   <= '0;
            // quotient would need more than QB bits, or divide by zero
            r_sat <= (i_interval == '0) || (dividend >= dvs_top);
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= diff;
            end
            r_q   <= {r_q[QB-2:0], ge};
            r_dvs <= r_dvs >> 1;
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quot = (r_sat || r_q[QB-1]) ? hrpi_pkg::RATE_MAX : r_q[QB-2:0];

endmodule

### tb/tb_heart_rate_from_peak_interval.sv
// Testbench for heart_rate_from_peak_interval: queued sample requests, rate predictor, checker.
`timescale 1ns / 1ps

module tb_heart_rate_from_peak_interval;

    localparam int INDEX_W   = 32;
    localparam int FRAC_W    = 7;
    localparam int SETTLE    = 40;    // lets a trailing divide finish after drain
    localparam int QUIET_MAX = 2000;  // cycles with no request moving on either side
    localparam int SHOW_MAX  = 10;

    // index 3 is not decoded; writes to it must leave everything alone
    localparam logic [hrpi_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic peak;
        logic frame_end;
    } t_sample;

    // DUT ports; the inputs are known from time zero
    logic                             i_clk       = 1'b0;
    logic                             i_rst_n     = 1'b0;
    logic                             i_cfg_we    = 1'b0;
    logic [hrpi_pkg::CFG_INDEX_W-1:0] i_cfg_index = hrpi_pkg::CFG_SAMPLE_RATE;
    logic [hrpi_pkg::CFG_DATA_W-1:0]  i_cfg_data  = '0;
    logic                             i_valid     = 1'b0;
    logic                             i_peak      = 1'b0;
    logic                             i_frame_end = 1'b0;
    logic                             i_ready     = 1'b0;
    logic                             o_ready;
    logic                             o_valid;
    logic [hrpi_pkg::RATE_W-1:0]      o_heart_rate;

    heart_rate_from_peak_interval #(
        .INDEX_WIDTH    (INDEX_W),
        .RATE_FRAC_BITS (FRAC_W)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_peak       (i_peak),
        .i_frame_end  (i_frame_end),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_heart_rate (o_heart_rate)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Rate predictor: own copy of registers and beat-tracking state.
    // Registers start at their reset values; reset is applied only once.
    // ------------------------------------------------------------------
    logic [15:0]                 fs_reg     = hrpi_pkg::SAMPLE_RATE_RST;
    logic                        smooth_reg = 1'b0;
    logic [INDEX_W-1:0]          idx_now    = '0;
    logic [INDEX_W-1:0]          idx_last   = '0;
    logic                        seen_peak  = 1'b0;
    logic [hrpi_pkg::RATE_W-1:0] rate_now   = hrpi_pkg::DEFAULT_RATE_RST;

    t_sample                     sample_q[$];   // sample requests not yet driven
    logic [hrpi_pkg::RATE_W-1:0] rate_q[$];     // rates owed to the output side

    int  n_bad       = 0;
    int  gap_left    = 0;
    int  stall_left  = 0;
    int  quiet_cycles = 0;
    bit  idle_on     = 1'b1;

    // 60 * fs * 2^FRAC / span, rounded half up, clamped at the top
    function automatic logic [hrpi_pkg::RATE_W-1:0] interval_rate(
        input logic [INDEX_W-1:0] span);
        logic [63:0] num;
        logic [63:0] quo;
        num = (64'd60 * fs_reg) << FRAC_W;
        if (span == '0)
            return hrpi_pkg::RATE_MAX;
        quo = (num + (span >> 1)) / span;
        return (quo > hrpi_pkg::RATE_MAX) ? hrpi_pkg::RATE_MAX : quo[hrpi_pkg::RATE_W-1:0];
    endfunction

    // Advance the beat tracker by one accepted sample; a frame end owes a rate.
    task automatic track_sample(input logic pk, input logic fe);
        logic [hrpi_pkg::RATE_W:0] r;
        if (pk) begin
            // first peak only anchors the interval
            if (seen_peak) begin
                r = {1'b0, interval_rate(idx_now - idx_last)};
                if (smooth_reg)
                    r = (r + rate_now) >> 1;
                rate_now = r[hrpi_pkg::RATE_W-1:0];
            end
            idx_last  = idx_now;
            seen_peak = 1'b1;
        end
        idx_now = idx_now + 1'b1;
        if (fe)
            rate_q.push_back(rate_now);
    endtask

    function automatic int draw_pause();
        return idle_on ? $urandom_range(0, 10) : 0;
    endfunction

    // ------------------------------------------------------------------
    // Driver: one sample request at a time, random pause after each while idle_on is set.
    // i_valid is assigned once per edge so a held request never glitches.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_sample nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (i_valid && o_ready)
                track_sample(i_peak, i_frame_end);
            if (!i_valid || o_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (sample_q.size() > 0) begin
                    nxt = sample_q.pop_front();
                    i_valid     <= 1'b1;
                    i_peak      <= nxt.peak;
                    i_frame_end <= nxt.frame_end;
                    gap_left = draw_pause();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: takes rate requests, stalls a random count after each one while
    // idle_on is set, and checks against the oldest owed rate.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        logic                        rdy;
        logic [hrpi_pkg::RATE_W-1:0] want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            stall_left = 0;
        end else begin
            rdy = i_ready;
            if (o_valid && i_ready) begin
                if (rate_q.size() == 0) begin
                    n_bad++;
                    if (n_bad <= SHOW_MAX)
                        $display("%0t: unexpected rate request, got %0d", $realtime,
                                 o_heart_rate);
                end else begin
                    want = rate_q.pop_front();
                    if (o_heart_rate !== want) begin
                        n_bad++;
                        if (n_bad <= SHOW_MAX)
                            $display("%0t: heart_rate expected %0d, got %0d", $realtime,
                                     want, o_heart_rate);
                    end
                end
                stall_left = draw_pause();
                rdy = (stall_left == 0);
            end else if (!i_ready) begin
                if (stall_left > 0)
                    stall_left--;
                rdy = (stall_left == 0);
            end
            i_ready <= rdy;
        end
    end

    // Watchdog: a stuck handshake on both sides ends the run.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_MAX) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Registers are only written with nothing in flight; see drain().
    task automatic cfg_write(input logic [hrpi_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [hrpi_pkg::CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            hrpi_pkg::CFG_SAMPLE_RATE:   fs_reg = val;
            // reload restarts the rate, index state stays
            hrpi_pkg::CFG_DEFAULT_RATE:  rate_now = val;
            hrpi_pkg::CFG_SMOOTH_ENABLE: smooth_reg = val[0];
            default: ;
        endcase
    endtask

    task automatic push_sample(input logic pk, input logic fe);
        t_sample s;
        s.peak      = pk;
        s.frame_end = fe;
        sample_q.push_back(s);
    endtask

    function automatic logic frame_draw();
        return ($urandom_range(0, 4) == 0);
    endfunction

    // Beat trains: runs of quiet samples closed by a peak, frame ends sprinkled
    // in; a little noise and some very short intervals mixed in.
    task automatic queue_beats(input int n);
        int left;
        int span;
        int sel;
        left = n;
        while (left > 0) begin
            sel = $urandom_range(0, 19);
            if (sel < 2) begin
                push_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                left--;
            end else begin
                if (sel < 6)
                    span = $urandom_range(1, 3);
                else if (sel < 19)
                    span = $urandom_range(4, 60);
                else
                    span = $urandom_range(60, 200);
                repeat (span - 1) push_sample(1'b0, frame_draw());
                push_sample(1'b1, frame_draw());
                left -= span;
            end
        end
    endtask

    // Wait for every request to move and every rate to come back, then let
    // any trailing divide (a peak with no frame end) finish.
    task automatic drain();
        while (sample_q.size() != 0 || i_valid || rate_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic run_phase(input int n, input logic [15:0] fs,
                             input logic [15:0] dflt, input logic sm, input bit idle);
        cfg_write(hrpi_pkg::CFG_SAMPLE_RATE, fs);
        cfg_write(hrpi_pkg::CFG_DEFAULT_RATE, dflt);
        cfg_write(hrpi_pkg::CFG_SMOOTH_ENABLE, {15'd0, sm});
        idle_on = idle;
        queue_beats(n);
        drain();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values: default rate before any peak, first peak, saturation
        push_sample(1'b0, 1'b1);
        push_sample(1'b0, 1'b0);
        push_sample(1'b1, 1'b0);
        push_sample(1'b1, 1'b1);   // back-to-back peaks: clamps at the top
        push_sample(1'b0, 1'b0);
        push_sample(1'b1, 1'b1);
        push_sample(1'b0, 1'b1);
        drain();

        // undecoded index must be ignored; slowest rate, smoothing from the top
        cfg_write(CFG_UNUSED, 16'hFFFF);
        cfg_write(hrpi_pkg::CFG_SAMPLE_RATE, 16'd1);
        cfg_write(hrpi_pkg::CFG_SMOOTH_ENABLE, 16'd1);
        cfg_write(hrpi_pkg::CFG_DEFAULT_RATE, 16'hFFFF);
        push_sample(1'b0, 1'b1);
        push_sample(1'b1, 1'b0);
        push_sample(1'b0, 1'b0);
        push_sample(1'b0, 1'b0);
        push_sample(1'b1, 1'b1);
        push_sample(1'b1, 1'b0);
        push_sample(1'b0, 1'b1);
        drain();

        // fastest sample rate, smoothing off, reload to zero
        cfg_write(hrpi_pkg::CFG_SAMPLE_RATE, 16'hFFFF);
        cfg_write(hrpi_pkg::CFG_SMOOTH_ENABLE, 16'd0);
        cfg_write(hrpi_pkg::CFG_DEFAULT_RATE, 16'd0);
        push_sample(1'b0, 1'b1);
        push_sample(1'b1, 1'b1);
        push_sample(1'b0, 1'b1);
        drain();

        // random beat trains over several settings, extremes included
        run_phase(300, 16'd250, 16'd0, 1'b0, 1'b1);
        run_phase(300, 16'd1, 16'd1000, 1'b1, 1'b0);
        run_phase(300, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
        run_phase(300, 16'($urandom_range(20, 300)), 16'($urandom_range(0, 65535)),
                  1'($urandom_range(0, 1)), 1'b1);
        run_phase(300, 16'($urandom_range(1, 65535)), 16'($urandom_range(0, 65535)),
                  1'($urandom_range(0, 1)), 1'b0);
        run_phase(300, 16'($urandom_range(20, 300)), 16'($urandom_range(0, 65535)),
                  1'($urandom_range(0, 1)), 1'b1);

        if (n_bad == 0 && rate_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### sim.f
design/hrpi_pkg.sv
design/hrpi_div.sv
design/heart_rate_from_peak_interval.sv
tb/tb_heart_rate_from_peak_interval.sv
